// ----- rtl/clr_pkg.sv -----
package clr_pkg;

  localparam int GAP_LIMIT_MS_DEF = 500;
  localparam int LEVEL_FRAC_BITS  = 14;
  localparam logic [31:0] DECAY_STEP_Q32   = 32'd4085499269;
  localparam logic [31:0] RECOVER_STEP_Q32 = 32'd4286385946;
  localparam int PROD_W    = 49;
  localparam int DIV_CNT_W = 6;
  localparam int NUM_REGS  = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LEVEL,
    REG_END_LEVEL,
    REG_RAMP_DURATION,
    REG_CURRENT_LIMIT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_MUL_RAMP,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MUL_LEVEL,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic fill;
    logic capture;
    logic mul_ramp;
    logic div_load;
    logic div_step;
    logic mul_level;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic div_last;
  } dp_sts_t;

  function automatic logic [16:0] abs18(input logic signed [17:0] v);
    logic [17:0] t;
    t = v[17] ? 18'(-v) : 18'(v);
    return t[16:0];
  endfunction

endpackage

// ----- rtl/clr_if.sv -----
interface clr_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] now_ms;
  logic signed [15:0] phase_u_current;
  logic signed [15:0] phase_v_current;
  modport source (output valid, now_ms, phase_u_current, phase_v_current, input ready);
  modport sink (input valid, now_ms, phase_u_current, phase_v_current, output ready);
endinterface

interface clr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] applied_level;
  logic               ramp_done;
  logic               is_throttled;
  modport source (output valid, applied_level, ramp_done, is_throttled, input ready);
  modport sink (input valid, applied_level, ramp_done, is_throttled, output ready);
endinterface

interface clr_cfg_if;
  import clr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/clr_ram.sv -----
module clr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 500
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/clr_ctrl.sv -----
module clr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  clr_pkg::dp_sts_t  sts,
  output clr_pkg::dp_cmd_t  cmd
);
  import clr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL_RAMP;
        end
      end
      ST_MUL_RAMP: begin
        cmd.mul_ramp = 1'b1;
        state_next   = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_MUL_LEVEL;
      end
      ST_MUL_LEVEL: begin
        cmd.mul_level = 1'b1;
        state_next    = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/clr_dp.sv -----
module clr_dp #(
  parameter int GAP_LIMIT_MS = clr_pkg::GAP_LIMIT_MS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  clr_pkg::dp_cmd_t              cmd,
  output clr_pkg::dp_sts_t              sts,
  input  logic                          cfg_write,
  input  logic [clr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [31:0]                   now_ms,
  input  logic signed [15:0]            phase_u_current,
  input  logic signed [15:0]            phase_v_current,
  output logic signed [15:0]            applied_level,
  output logic                          ramp_done,
  output logic                          is_throttled
);
  import clr_pkg::*;

  localparam int AW = $clog2(GAP_LIMIT_MS);
  localparam logic [AW-1:0] FILL_LAST = AW'(GAP_LIMIT_MS - 1);

  // configuration
  logic signed [15:0] start_level, end_level;
  logic [31:0]        ramp_duration_ms;
  logic [15:0]        current_limit;
  logic               cfg_hit;

  assign cfg_hit = cfg_write && (cfg_index < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level      <= '0;
      end_level        <= '0;
      ramp_duration_ms <= '0;
      current_limit    <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_LEVEL:   start_level      <= cfg_data[15:0];
        REG_END_LEVEL:     end_level        <= cfg_data[15:0];
        REG_RAMP_DURATION: ramp_duration_ms <= cfg_data;
        REG_CURRENT_LIMIT: current_limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // table fill and storage
  logic [AW-1:0] fill_cnt;
  logic [31:0]   dec_x, rec_x;
  logic [63:0]   dec_prod, rec_prod;
  logic [63:0]   rdata;
  logic [31:0]   gap;

  assign dec_prod = dec_x * DECAY_STEP_Q32;
  assign rec_prod = rec_x * RECOVER_STEP_Q32;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= AW'(1);
      dec_x    <= DECAY_STEP_Q32;
      rec_x    <= RECOVER_STEP_Q32;
    end else if (cmd.fill) begin
      fill_cnt <= fill_cnt + AW'(1);
      dec_x    <= dec_prod[63:32];
      rec_x    <= rec_prod[63:32];
    end
  end

  assign sts.fill_last = (fill_cnt == FILL_LAST);

  clr_ram #(.WIDTH(64), .DEPTH(GAP_LIMIT_MS)) u_tab (
    .clk   (clk),
    .we    (cmd.fill),
    .waddr (fill_cnt),
    .wdata ({dec_x, rec_x}),
    .re    (cmd.capture),
    .raddr (gap[AW-1:0]),
    .rdata (rdata)
  );

  // ramp state
  logic               armed, throttled;
  logic [31:0]        ramp_start_time, previous_time;
  logic signed [15:0] level_now;

  // capture stage
  logic [31:0]        eff_start, eff_prev, el_raw, el_cl;
  logic               gap_ok;
  logic signed [17:0] sum_w;
  logic [16:0]        mag_u, mag_v, mag_w, peak;
  logic [31:0]        now_r, start_r, prev_r, el_r;
  logic               limited_r, over_r, clear_ok_r;
  logic signed [15:0] lvl_r;

  assign eff_start = armed ? ramp_start_time : now_ms;
  assign eff_prev  = armed ? previous_time : now_ms;
  assign gap       = now_ms - eff_prev;
  assign el_raw    = now_ms - eff_start;
  assign el_cl     = (el_raw > ramp_duration_ms) ? ramp_duration_ms : el_raw;
  assign gap_ok    = (gap != 32'd0) && (gap < 32'(GAP_LIMIT_MS));
  assign sum_w     = -(18'(phase_u_current) + 18'(phase_v_current));
  assign mag_u     = abs18(18'(phase_u_current));
  assign mag_v     = abs18(18'(phase_v_current));
  assign mag_w     = abs18(sum_w);

  always_comb begin
    peak = mag_u;
    if (mag_v > peak) peak = mag_v;
    if (mag_w > peak) peak = mag_w;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r      <= now_ms;
      start_r    <= eff_start;
      prev_r     <= eff_prev;
      el_r       <= el_cl;
      limited_r  <= (current_limit != 16'd0) && gap_ok;
      over_r     <= peak > {1'b0, current_limit};
      clear_ok_r <= ({3'd0, peak} * 20'd5) <= ({4'd0, current_limit} * 20'd4);
      lvl_r      <= armed ? level_now : start_level;
    end
  end

  // span and shared multiplier
  logic signed [16:0] span;
  logic [16:0]        span_mag;
  logic               trivial;

  assign span     = 17'(end_level) - 17'(start_level);
  assign span_mag = abs18(18'(span));
  assign trivial  = (ramp_duration_ms == 32'd0) ||
                    (({15'd0, span_mag} * 32'd10000) < (32'd1 << LEVEL_FRAC_BITS));

  logic [48:0]        num_r, prod_r;
  logic signed [16:0] q_s, desired_s, diff;
  logic signed [15:0] desired_c, desired_r;
  logic [16:0]        mul_a;
  logic [31:0]        mul_b, one_minus_rec;
  logic               mul_neg, neg_r;
  logic [48:0]        mul_out;

  assign q_s           = span[16] ? -$signed({1'b0, num_r[15:0]}) : $signed({1'b0, num_r[15:0]});
  assign desired_s     = 17'(start_level) + q_s;
  assign desired_c     = desired_s[15:0];
  assign diff          = 17'(desired_c) - 17'(lvl_r);
  assign one_minus_rec = 32'(33'h1_0000_0000 - {1'b0, rdata[31:0]});

  always_comb begin
    if (cmd.mul_ramp) begin
      mul_a   = span_mag;
      mul_b   = el_r;
      mul_neg = span[16];
    end else if (over_r) begin
      mul_a   = abs18(18'(lvl_r));
      mul_b   = rdata[63:32];
      mul_neg = lvl_r[15];
    end else begin
      mul_a   = abs18(18'(diff));
      mul_b   = one_minus_rec;
      mul_neg = diff[16];
    end
  end

  assign mul_out = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_ramp || cmd.mul_level) begin
      prod_r <= mul_out;
      neg_r  <= mul_neg;
    end
    if (cmd.mul_level) begin
      desired_r <= desired_c;
    end
  end

  // restoring divider for the ramp fraction
  logic [31:0]          rem_r;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic [DIV_CNT_W-1:0] div_cnt;

  assign rem_sh       = {rem_r, num_r[48]};
  assign ge           = rem_sh >= {1'b0, ramp_duration_ms};
  assign sts.div_last = (div_cnt == DIV_CNT_W'(PROD_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num_r   <= prod_r + 49'(ramp_duration_ms >> 1);
      rem_r   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= ge ? 32'(rem_sh - {1'b0, ramp_duration_ms}) : rem_sh[31:0];
      num_r   <= {num_r[47:0], ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // level update
  logic [48:0]        rnd;
  logic signed [16:0] rv;
  logic signed [15:0] floor_lvl, lvl_upd, lvl_fin, rv_lvl;
  logic               thr_upd, thr_fin, done_fin;

  assign rnd       = prod_r + 49'h0_8000_0000;
  assign rv        = neg_r ? -$signed({1'b0, rnd[47:32]}) : $signed({1'b0, rnd[47:32]});
  assign rv_lvl    = rv[15:0];
  assign floor_lvl = end_level >>> 1;

  always_comb begin
    thr_upd = throttled;
    if (!limited_r) begin
      lvl_upd = desired_r;
    end else if (over_r) begin
      thr_upd = 1'b1;
      lvl_upd = (rv_lvl < floor_lvl) ? floor_lvl : rv_lvl;
    end else begin
      if (throttled && clear_ok_r) thr_upd = 1'b0;
      lvl_upd = 16'(17'(lvl_r) + rv);
    end
    if (trivial) begin
      lvl_fin  = end_level;
      thr_fin  = throttled;
      done_fin = 1'b1;
    end else if ((el_r >= ramp_duration_ms) && !thr_upd) begin
      lvl_fin  = end_level;
      thr_fin  = thr_upd;
      done_fin = 1'b1;
    end else begin
      lvl_fin  = lvl_upd;
      thr_fin  = thr_upd;
      done_fin = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      throttled <= 1'b0;
    end else if (cfg_hit) begin
      armed     <= 1'b0;
      throttled <= 1'b0;
    end else if (cmd.commit) begin
      armed     <= 1'b1;
      throttled <= thr_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ramp_start_time <= start_r;
      previous_time   <= trivial ? prev_r : now_r;
      level_now       <= lvl_fin;
      applied_level   <= lvl_fin;
      ramp_done       <= done_fin;
      is_throttled    <= thr_fin;
    end
  end
endmodule

// ----- rtl/current_limited_ramp_top.sv -----
// Current limited level ramp. Each accepted tick (time in ms and two phase
// currents) yields one result: the applied level, a done flag and the
// throttle flag. The level follows a linear ramp from start to end level;
// with a nonzero current limit and a tick gap of 1 to GAP_LIMIT_MS-1 ms it
// decays toward half the end level while the peak phase current is over the
// limit and recovers toward the ramp otherwise. The ramp fraction is formed
// by a one-bit-per-cycle 49-bit divider; ticks are processed one at a time
// and the next may be taken while a result waits at the output. While the
// decay and recovery tables are built after reset, no tick is taken;
// configuration writes are always taken and a write to one of the four
// registers re-arms the ramp.
module current_limited_ramp_top #(
  parameter int GAP_LIMIT_MS = clr_pkg::GAP_LIMIT_MS_DEF
) (
  input logic          clk,
  input logic          rst,
  clr_cfg_if.sink      cfg,
  clr_in_if.sink       in_ch,
  clr_out_if.source    out_ch
);
  import clr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg.ready = 1'b1;

  clr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  clr_dp #(.GAP_LIMIT_MS(GAP_LIMIT_MS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_write       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .now_ms          (in_ch.now_ms),
    .phase_u_current (in_ch.phase_u_current),
    .phase_v_current (in_ch.phase_v_current),
    .applied_level   (out_ch.applied_level),
    .ramp_done       (out_ch.ramp_done),
    .is_throttled    (out_ch.is_throttled)
  );
endmodule
